@@ rtl/sebc_pkg.sv @@
package sebc_pkg;

	// controller phases
	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_RSEND = 3'd1,
		PH_RRECV = 3'd2,
		PH_WSEND = 3'd3,
		PH_WPOLL = 3'd4
	} phase_t;

	// item kinds
	localparam logic [1:0] KIND_READ  = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_SLOT  = 2'd2;
	localparam logic [1:0] KIND_TICK  = 2'd3;

	// completion status
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BADADDR  = 2'd1;
	localparam logic [1:0] ST_MISMATCH = 2'd2;
	localparam logic [1:0] ST_TIMEOUT  = 2'd3;

	// configuration register indexes
	localparam logic [1:0] REG_ADDR_BITS    = 2'd0;
	localparam logic [1:0] REG_SECTOR_COUNT = 2'd1;
	localparam logic [1:0] REG_TIMEOUT      = 2'd2;

	localparam logic [3:0]  RST_ADDR_BITS    = 4'd6;
	localparam logic [10:0] RST_SECTOR_COUNT = 11'd64;
	localparam logic [15:0] RST_TIMEOUT      = 16'd10;

	localparam logic [3:0] MAX_ADDR_BITS = 4'd14;
	localparam logic [1:0] MAX_ATTEMPTS  = 2'd3;
	localparam logic [6:0] DROP_BITS     = 7'd4;
	localparam logic [6:0] BLOCK_BITS    = 7'd64;
	localparam logic [6:0] RECV_BITS     = BLOCK_BITS + DROP_BITS;

	typedef struct packed {
		logic [3:0]  addr_bits;
		logic [10:0] sector_count;
		logic [15:0] timeout_ticks;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] sector;
		logic [63:0] write_data;
		logic        serial_in;
	} item_t;

	typedef struct packed {
		logic        serial_out;
		logic        serial_drive;
		logic        busy_res;
		logic        done_res;
		logic [1:0]  status;
		logic [63:0] read_data;
	} result_t;

endpackage

@@ rtl/sebc_engine.sv @@
module sebc_engine
	import sebc_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    fire,
	input  item_t   item,
	input  cfg_t    cfg,
	output result_t res
);

	phase_t      phase_q, phase_d;
	logic [6:0]  bit_count_q, bit_count_d;
	logic [63:0] shift_q, shift_d;
	logic [13:0] addr_q, addr_d;
	logic [63:0] data_q, data_d;
	logic [1:0]  attempts_q, attempts_d;
	logic [15:0] tick_left_q, tick_left_d;
	logic        timed_out_q, timed_out_d;
	logic        is_write_q, is_write_d;

	logic [3:0]  a_w;
	logic [6:0]  addr_end;
	logic [6:0]  data_end;
	logic [6:0]  frame_len;
	logic [6:0]  b_inc;
	logic [3:0]  addr_idx;
	logic [6:0]  data_pos;
	logic [63:0] shift_rx;
	logic [1:0]  att_inc;
	logic        att_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			bit_count_q <= '0;
			attempts_q  <= '0;
			tick_left_q <= '0;
			timed_out_q <= 1'b0;
			is_write_q  <= 1'b0;
		end else if (fire) begin
			phase_q     <= phase_d;
			bit_count_q <= bit_count_d;
			attempts_q  <= attempts_d;
			tick_left_q <= tick_left_d;
			timed_out_q <= timed_out_d;
			is_write_q  <= is_write_d;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			shift_q <= shift_d;
			addr_q  <= addr_d;
			data_q  <= data_d;
		end
	end

	assign a_w       = (cfg.addr_bits > MAX_ADDR_BITS) ? MAX_ADDR_BITS : cfg.addr_bits;
	assign addr_end  = {3'd0, a_w} + 7'd2;
	assign data_end  = addr_end + BLOCK_BITS;
	assign frame_len = (phase_q == PH_RSEND) ? addr_end + 7'd1 : data_end + 7'd1;
	assign b_inc     = bit_count_q + 7'd1;
	// address goes out msb first, index stays below 14 inside the address field
	assign addr_idx  = a_w + 4'd1 - bit_count_q[3:0];
	assign data_pos  = bit_count_q - addr_end;
	assign shift_rx  = (bit_count_q >= DROP_BITS) ? {shift_q[62:0], item.serial_in} : shift_q;
	assign att_inc   = attempts_q + 2'd1;
	assign att_last  = att_inc >= MAX_ATTEMPTS;

	always_comb begin
		phase_d     = phase_q;
		bit_count_d = bit_count_q;
		shift_d     = shift_q;
		addr_d      = addr_q;
		data_d      = data_q;
		attempts_d  = attempts_q;
		tick_left_d = tick_left_q;
		timed_out_d = timed_out_q;
		is_write_d  = is_write_q;
		res         = '0;

		case (item.kind)
			KIND_READ, KIND_WRITE: begin
				if (phase_q == PH_IDLE) begin
					if (item.sector >= {5'd0, cfg.sector_count}) begin
						res.done_res = 1'b1;
						res.status   = ST_BADADDR;
					end else begin
						addr_d      = item.sector[13:0];
						bit_count_d = '0;
						if (item.kind == KIND_WRITE) begin
							data_d     = item.write_data;
							is_write_d = 1'b1;
							attempts_d = '0;
							phase_d    = PH_WSEND;
						end else begin
							is_write_d = 1'b0;
							phase_d    = PH_RSEND;
						end
					end
				end
			end
			KIND_TICK: begin
				if (phase_q == PH_WPOLL && tick_left_q != '0) begin
					tick_left_d = tick_left_q - 16'd1;
					if (tick_left_q == 16'd1)
						timed_out_d = 1'b1;
				end
			end
			KIND_SLOT: begin
				case (phase_q)
					PH_RSEND, PH_WSEND: begin
						res.serial_drive = 1'b1;
						if (bit_count_q == 7'd0) begin
							res.serial_out = 1'b1;
						end else if (bit_count_q == 7'd1) begin
							res.serial_out = (phase_q == PH_RSEND);
						end else if (bit_count_q < addr_end) begin
							res.serial_out = addr_q[addr_idx];
						end else if (phase_q == PH_WSEND && bit_count_q < data_end) begin
							// data word leaves msb first
							res.serial_out = data_q[~data_pos[5:0]];
						end
						bit_count_d = b_inc;
						if (b_inc >= frame_len) begin
							bit_count_d = '0;
							if (phase_q == PH_RSEND) begin
								phase_d = PH_RRECV;
								shift_d = '0;
							end else begin
								phase_d     = PH_WPOLL;
								tick_left_d = cfg.timeout_ticks;
								timed_out_d = 1'b0;
							end
						end
					end
					PH_RRECV: begin
						shift_d     = shift_rx;
						bit_count_d = b_inc;
						if (b_inc >= RECV_BITS) begin
							bit_count_d = '0;
							if (!is_write_q) begin
								phase_d       = PH_IDLE;
								res.done_res  = 1'b1;
								res.status    = ST_OK;
								res.read_data = shift_rx;
							end else if (shift_rx == data_q) begin
								phase_d      = PH_IDLE;
								res.done_res = 1'b1;
								res.status   = ST_OK;
							end else begin
								attempts_d = att_inc;
								if (att_last) begin
									phase_d      = PH_IDLE;
									res.done_res = 1'b1;
									res.status   = ST_MISMATCH;
								end else begin
									phase_d = PH_WSEND;
								end
							end
						end
					end
					PH_WPOLL: begin
						if (item.serial_in) begin
							phase_d     = PH_RSEND;
							bit_count_d = '0;
						end else if (timed_out_q) begin
							attempts_d = att_inc;
							if (att_last) begin
								phase_d      = PH_IDLE;
								res.done_res = 1'b1;
								res.status   = ST_TIMEOUT;
							end else begin
								phase_d     = PH_WSEND;
								bit_count_d = '0;
							end
						end
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase

		res.busy_res = (phase_d != PH_IDLE);
	end

`ifndef ASSERT_OFF
	a_drive_in_send: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.serial_drive |-> (phase_q == PH_RSEND || phase_q == PH_WSEND))
		else $error("serial line driven outside a send frame");

	a_done_goes_idle: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.done_res |=> phase_q == PH_IDLE)
		else $error("controller still busy after finishing");

	a_attempts_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_IDLE) && is_write_q |-> attempts_q < MAX_ATTEMPTS)
		else $error("write retried past the attempt limit");

	a_rdata_on_read: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (res.read_data != '0) |-> res.done_res && !is_write_q)
		else $error("read data shown outside a finished read");

	a_idle_count: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE |-> bit_count_q == '0)
		else $error("bit count left over in idle");
`endif

endmodule

@@ rtl/serial_eeprom_block_controller.sv @@
// channel | handshake            | payload
// req     | req_valid, req_stall | kind, sector, write_data, serial_in
// rsp     | rsp_valid, rsp_stall | serial_out, serial_drive, busy_res, done_res, status, read_data
// cfg     | cfg_we               | cfg_index, cfg_data
//
// one word per cycle sustained while results are not stalled; each word gets exactly one result word
// an accepted word is registered in the item register, then goes through one pass
// of the controller into the result register
// reset clears both valid stages, loads register defaults and leaves the controller idle
// a stalled result holds; words keep coming in as long as the item stage is free or moving
module serial_eeprom_block_controller
	import sebc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  kind,
	input  logic [15:0] sector,
	input  logic [63:0] write_data,
	input  logic        serial_in,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic        serial_out,
	output logic        serial_drive,
	output logic        busy_res,
	output logic        done_res,
	output logic [1:0]  status,
	output logic [63:0] read_data,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	cfg_t    cfg_q;
	logic    valid_s1;
	item_t   item_s1;
	logic    rsp_valid_q;
	result_t rsp_q;
	result_t res;
	logic    advance;
	logic    req_take;

	assign advance   = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && !advance;
	assign req_take  = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.addr_bits     <= RST_ADDR_BITS;
			cfg_q.sector_count  <= RST_SECTOR_COUNT;
			cfg_q.timeout_ticks <= RST_TIMEOUT;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ADDR_BITS:    cfg_q.addr_bits     <= cfg_data[3:0];
				REG_SECTOR_COUNT: cfg_q.sector_count  <= cfg_data[10:0];
				REG_TIMEOUT:      cfg_q.timeout_ticks <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (req_take)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
			if (advance)
				rsp_valid_q <= 1'b1;
			else if (!rsp_stall)
				rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_take) begin
			item_s1.kind       <= kind;
			item_s1.sector     <= sector;
			item_s1.write_data <= write_data;
			item_s1.serial_in  <= serial_in;
		end
		if (advance)
			rsp_q <= res;
	end

	sebc_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.item   (item_s1),
		.cfg    (cfg_q),
		.res    (res)
	);

	assign rsp_valid    = rsp_valid_q;
	assign serial_out   = rsp_q.serial_out;
	assign serial_drive = rsp_q.serial_drive;
	assign busy_res     = rsp_q.busy_res;
	assign done_res     = rsp_q.done_res;
	assign status       = rsp_q.status;
	assign read_data    = rsp_q.read_data;

endmodule

@@ tb/eeprom_result_checker.sv @@
`timescale 1ns / 100ps

module eeprom_result_checker
	import sebc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	input  logic        req_stall,
	input  logic [1:0]  kind,
	input  logic [15:0] sector,
	input  logic [63:0] write_data,
	input  logic        serial_in,
	input  logic        rsp_valid,
	input  logic        rsp_stall,
	input  logic        serial_out,
	input  logic        serial_drive,
	input  logic        busy_res,
	input  logic        done_res,
	input  logic [1:0]  status,
	input  logic [63:0] read_data,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          fail_count,
	output int          pending
);

	// register copies
	logic [3:0]  cfg_ab;
	logic [10:0] cfg_sc;
	logic [15:0] cfg_to;

	// controller copy
	phase_t      ctl_phase;
	logic [6:0]  nbits;
	logic [63:0] shreg;
	logic [13:0] addr_q;
	logic [63:0] data_q;
	logic [1:0]  tries;
	logic [15:0] ticks_left;
	logic        tmo;
	logic        wr;

	result_t     due_words[$];
	item_t       seen_item;
	result_t     model_word;
	result_t     want;
	result_t     got;

	task automatic count_failed_try(input logic [1:0] why, inout result_t r);
		tries = tries + 2'd1;
		if (tries >= MAX_ATTEMPTS) begin
			ctl_phase = PH_IDLE;
			r.done_res = 1'b1;
			r.status = why;
		end else begin
			ctl_phase = PH_WSEND;
			nbits = '0;
		end
	endtask

	task automatic step_controller(input item_t it, output result_t r);
		int unsigned a;
		int unsigned b;
		int unsigned len;
		logic [13:0] addr_sh;
		r = '0;
		a = (cfg_ab > MAX_ADDR_BITS) ? 14 : cfg_ab;
		case (it.kind)
			KIND_READ, KIND_WRITE: begin
				if (ctl_phase == PH_IDLE) begin
					if (it.sector >= cfg_sc) begin
						r.done_res = 1'b1;
						r.status = ST_BADADDR;
					end else begin
						addr_q = it.sector[13:0];
						nbits = '0;
						if (it.kind == KIND_WRITE) begin
							data_q = it.write_data;
							wr = 1'b1;
							tries = '0;
							ctl_phase = PH_WSEND;
						end else begin
							wr = 1'b0;
							ctl_phase = PH_RSEND;
						end
					end
				end
			end
			KIND_TICK: begin
				if (ctl_phase == PH_WPOLL && ticks_left != 0) begin
					ticks_left = ticks_left - 16'd1;
					if (ticks_left == 0)
						tmo = 1'b1;
				end
			end
			default: begin
				if (ctl_phase == PH_RSEND || ctl_phase == PH_WSEND) begin
					b = nbits;
					len = (ctl_phase == PH_RSEND) ? a + 3 : a + 67;
					r.serial_drive = 1'b1;
					if (b == 0)
						r.serial_out = 1'b1;
					else if (b == 1)
						r.serial_out = (ctl_phase == PH_RSEND);
					else if (b < a + 2) begin
						addr_sh = addr_q >> ((a - 1 - (b - 2)) & 32'd15);
						r.serial_out = addr_sh[0];
					end else if (ctl_phase == PH_WSEND && b < a + 66)
						r.serial_out = data_q[(63 - (b - a - 2)) & 32'd63];
					nbits = nbits + 7'd1;
					if (b + 1 >= len) begin
						nbits = '0;
						if (ctl_phase == PH_RSEND) begin
							ctl_phase = PH_RRECV;
							shreg = '0;
						end else begin
							ctl_phase = PH_WPOLL;
							ticks_left = cfg_to;
							tmo = 1'b0;
						end
					end
				end else if (ctl_phase == PH_RRECV) begin
					if (nbits >= DROP_BITS)
						shreg = {shreg[62:0], it.serial_in};
					nbits = nbits + 7'd1;
					if (nbits >= RECV_BITS) begin
						nbits = '0;
						if (!wr) begin
							ctl_phase = PH_IDLE;
							r.done_res = 1'b1;
							r.status = ST_OK;
							r.read_data = shreg;
						end else if (shreg == data_q) begin
							ctl_phase = PH_IDLE;
							r.done_res = 1'b1;
							r.status = ST_OK;
						end else
							count_failed_try(ST_MISMATCH, r);
					end
				end else if (ctl_phase == PH_WPOLL) begin
					// ready wins even when the timeout already ran out
					if (it.serial_in) begin
						ctl_phase = PH_RSEND;
						nbits = '0;
					end else if (tmo)
						count_failed_try(ST_TIMEOUT, r);
				end
			end
		endcase
		r.busy_res = (ctl_phase != PH_IDLE);
	endtask

	task automatic check_field(input string fname, input logic [63:0] exp_v, act_v);
		if (exp_v !== act_v) begin
			if (fail_count < 10)
				$display("mismatch on %s: expected %h, got %h", fname, exp_v, act_v);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_ab = RST_ADDR_BITS;
			cfg_sc = RST_SECTOR_COUNT;
			cfg_to = RST_TIMEOUT;
			ctl_phase = PH_IDLE;
			nbits = '0;
			shreg = '0;
			addr_q = '0;
			data_q = '0;
			tries = '0;
			ticks_left = '0;
			tmo = 1'b0;
			wr = 1'b0;
			due_words.delete();
			fail_count = 0;
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_ADDR_BITS:    cfg_ab = cfg_data[3:0];
					REG_SECTOR_COUNT: cfg_sc = cfg_data[10:0];
					REG_TIMEOUT:      cfg_to = cfg_data;
					default: ;
				endcase
			end
			if (req_valid && !req_stall) begin
				seen_item.kind = kind;
				seen_item.sector = sector;
				seen_item.write_data = write_data;
				seen_item.serial_in = serial_in;
				step_controller(seen_item, model_word);
				due_words.push_back(model_word);
			end
			if (rsp_valid && !rsp_stall) begin
				if (due_words.size() == 0) begin
					if (fail_count < 10)
						$display("result word with nothing expected");
					fail_count++;
				end else begin
					want = due_words.pop_front();
					got = '{serial_out, serial_drive, busy_res, done_res, status, read_data};
					check_field("serial_out", 64'(want.serial_out), 64'(got.serial_out));
					check_field("serial_drive", 64'(want.serial_drive),
						64'(got.serial_drive));
					check_field("busy_res", 64'(want.busy_res), 64'(got.busy_res));
					check_field("done_res", 64'(want.done_res), 64'(got.done_res));
					check_field("status", 64'(want.status), 64'(got.status));
					check_field("read_data", want.read_data, got.read_data);
				end
			end
			pending <= due_words.size();
		end
	end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
	import sebc_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	logic [1:0]  kind = KIND_SLOT;
	logic [15:0] sector = '0;
	logic [63:0] write_data = '0;
	logic        serial_in = 1'b0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	logic        serial_out;
	logic        serial_drive;
	logic        busy_res;
	logic        done_res;
	logic [1:0]  status;
	logic [63:0] read_data;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = REG_ADDR_BITS;
	logic [15:0] cfg_data = '0;
	int          fail_count;
	int          pending;

	int          tx_idle_pct = 0;
	int          rx_stall_pct = 0;
	int          tx_quiet = 0;
	int          rx_quiet = 0;
	int          words_sent = 0;
	int unsigned cur_a = 6;
	int unsigned cur_sc = 64;
	int unsigned cur_to = 10;
	int          step;
	int          budget;

	serial_eeprom_block_controller dut (.*);

	eeprom_result_checker u_check (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver stalls, with occasional stretches of none
	always @(posedge clk) begin
		if (rx_quiet != 0) begin
			rx_quiet <= rx_quiet - 1;
			rsp_stall <= 1'b0;
		end else if (rx_stall_pct != 0 && $urandom_range(0, 59) == 0) begin
			rx_quiet <= 30;
			rsp_stall <= 1'b0;
		end else
			rsp_stall <= ($urandom_range(0, 99) < rx_stall_pct);
	end

	function automatic logic [63:0] rand_block();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic send_word(input logic [1:0] k, input logic [15:0] sec,
			input logic [63:0] wd, input logic sin);
		logic took;
		if (tx_quiet > 0)
			tx_quiet--;
		else if (tx_idle_pct != 0 && $urandom_range(0, 49) == 0)
			tx_quiet = 30;
		while (tx_quiet == 0 && $urandom_range(0, 99) < tx_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		kind <= k;
		sector <= sec;
		write_data <= wd;
		serial_in <= sin;
		do begin
			@(negedge clk);
			took = !req_stall;
			@(posedge clk);
		end while (!took);
		words_sent++;
	endtask

	task automatic slot(input logic sin);
		send_word(KIND_SLOT, 16'($urandom_range(0, 16'hFFFF)), rand_block(), sin);
	endtask

	task automatic tick();
		send_word(KIND_TICK, 16'($urandom_range(0, 16'hFFFF)), rand_block(),
			1'($urandom_range(0, 1)));
	endtask

	task automatic hold_until_drained();
		req_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	// requests that land while busy, and ticks where allowed
	task automatic jitter(input bit tick_ok);
		if ($urandom_range(0, 29) == 0)
			send_word($urandom_range(0, 1) ? KIND_WRITE : KIND_READ,
				16'($urandom_range(0, 16'hFFFF)), rand_block(), 1'($urandom_range(0, 1)));
		else if (tick_ok && $urandom_range(0, 11) == 0)
			tick();
	endtask

	function automatic logic [15:0] pick_sector();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return 16'(cur_sc - 1);
			default: return 16'($urandom_range(0, cur_sc - 1));
		endcase
	endfunction

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic load_registers(input int unsigned ab, sc, to);
		hold_until_drained();
		repeat (4) @(posedge clk);
		write_reg(REG_ADDR_BITS, 16'(ab));
		write_reg(REG_SECTOR_COUNT, 16'(sc));
		write_reg(REG_TIMEOUT, 16'(to));
		cfg_we <= 1'b0;
		cur_a = (ab > 14) ? 14 : ab;
		cur_sc = sc;
		cur_to = to;
	endtask

	task automatic read_txn();
		send_word(KIND_READ, pick_sector(), rand_block(), 1'($urandom_range(0, 1)));
		repeat (cur_a + 3 + 68) begin
			jitter(1'b1);
			slot(1'($urandom_range(0, 1)));
		end
	endtask

	task automatic write_txn();
		logic [63:0] blk;
		int fails;
		bit ok;
		bit got_ready;
		bit late;
		bit flip;
		int nt;
		int pos;
		int i;
		blk = rand_block();
		fails = 0;
		ok = 1'b0;
		send_word(KIND_WRITE, pick_sector(), blk, 1'($urandom_range(0, 1)));
		while (!ok && fails < 3) begin
			repeat (cur_a + 67) begin
				jitter(1'b1);
				slot(1'($urandom_range(0, 1)));
			end
			if ($urandom_range(0, 3) == 0)
				hold_until_drained();
			// polling: no stray ticks here, they would shift the timeout
			if (cur_to != 0 && cur_to <= 12 && $urandom_range(0, 3) == 0) begin
				late = ($urandom_range(0, 2) == 0);
				repeat (cur_to) begin
					if ($urandom_range(0, 1)) begin
						jitter(1'b0);
						slot(1'b0);
					end
					jitter(1'b0);
					tick();
				end
				got_ready = late;
			end else begin
				if (cur_to == 0)
					nt = $urandom_range(0, 4);
				else
					nt = $urandom_range(0, (cur_to - 1 < 4) ? cur_to - 1 : 4);
				repeat (nt) begin
					if ($urandom_range(0, 1)) begin
						jitter(1'b0);
						slot(1'b0);
					end
					jitter(1'b0);
					tick();
				end
				got_ready = 1'b1;
			end
			jitter(1'b0);
			slot(got_ready);
			if (!got_ready)
				fails++;
			else begin
				flip = ($urandom_range(0, 3) == 0);
				pos = $urandom_range(0, 63);
				// read-back command frame
				repeat (cur_a + 3) begin
					jitter(1'b1);
					slot(1'($urandom_range(0, 1)));
				end
				repeat (4) begin
					jitter(1'b1);
					slot(1'($urandom_range(0, 1)));
				end
				for (i = 63; i >= 0; i--) begin
					jitter(1'b1);
					slot(blk[i] ^ (flip && i == pos));
				end
				if (flip)
					fails++;
				else
					ok = 1'b1;
			end
		end
	endtask

	task automatic idle_noise();
		int n;
		n = $urandom_range(1, 6);
		repeat (n) begin
			case ($urandom_range(0, 2))
				0: slot(1'($urandom_range(0, 1)));
				1: tick();
				default: send_word($urandom_range(0, 1) ? KIND_WRITE : KIND_READ,
					16'($urandom_range(cur_sc, 16'hFFFF)), rand_block(),
					1'($urandom_range(0, 1)));
			endcase
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// idle corner words and rejected addresses
		slot(1'b1);
		slot(1'b0);
		tick();
		send_word(KIND_READ, 16'd64, '0, 1'b1);
		send_word(KIND_WRITE, 16'hFFFF, '1, 1'b0);
		send_word(KIND_READ, 16'h8000, '1, 1'b0);
		send_word(KIND_WRITE, 16'h7FFF, '0, 1'b1);

		for (step = 0; step < 8; step++) begin
			case (step)
				1: load_registers(14, 1024, 1);
				2: load_registers(6, 1, 3);
				3: load_registers(15, $urandom_range(1, 1024), 0);
				4: load_registers($urandom_range(6, 14), $urandom_range(1, 1024), 65535);
				5: load_registers(14, 1, 12);
				6: load_registers(15, 1024, $urandom_range(1, 12));
				7: load_registers($urandom_range(6, 14), $urandom_range(1, 64),
					$urandom_range(1, 8));
				default: ;
			endcase
			case (step % 4)
				0: begin tx_idle_pct = 0; rx_stall_pct = 0; end
				1: begin tx_idle_pct = 68; rx_stall_pct = 0; end
				2: begin tx_idle_pct = 0; rx_stall_pct = 68; end
				default: begin tx_idle_pct = 33; rx_stall_pct = 33; end
			endcase
			budget = words_sent + 125;
			while (words_sent < budget) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3: read_txn();
					4, 5, 6, 7: write_txn();
					default: idle_noise();
				endcase
			end
		end

		hold_until_drained();
		repeat (8) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
